// ===== hw/rtl/ptsm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptsm_pkg
// Shared types and codes for the page table with swap marks: operation,
// status and entry class codes, register indexes and the control states.
// ----------------------------------------------------------------------------
package ptsm_pkg;

    // default geometry
    localparam int TABLE_ENTRIES_DEF = 32;
    localparam int PAGE_SHIFT_DEF    = 12;

    // fixed field widths
    localparam int ADDR_W  = 32;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;
    localparam int CLASS_W = 3;
    localparam int PAGES_W = 6;
    localparam int CFG_IDX_W = 1;

    // operation codes
    localparam logic [OP_W-1:0] OP_LOOKUP   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD      = 3'd1;
    localparam logic [OP_W-1:0] OP_SWAP_OUT = 3'd2;
    localparam logic [OP_W-1:0] OP_READ_OFS = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_OUTSIDE   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_STATE = 2'd2;

    // entry classes and clear events
    localparam logic [CLASS_W-1:0] CLS_EMPTY     = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_SWAPPED   = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_RESIDENT  = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_FREE_SWAP = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_FREE_PAGE = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VA_BASE      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'd1;

    // control states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DONE
    } state_t;

endpackage

// ===== hw/rtl/ptsm_ram.sv =====
// ----------------------------------------------------------------------------
// ptsm_ram
// Generic single-port-write, single-port-read synchronous RAM with a
// registered read and no reset on the data.
// ----------------------------------------------------------------------------
module ptsm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/page_table_with_swap_marks.sv =====
// ----------------------------------------------------------------------------
// page_table_with_swap_marks
// Single-level page table held in a synchronous RAM, with lookup, add or
// swap-in, swap-out, swap offset read and a clear walk that frees entries.
// ----------------------------------------------------------------------------
// result: a single-entry op gives its one result in the cycle after start is taken
// busy: held through a single-entry op, so the next start waits for its RAM read-modify-write
// clear: walks the entries below the limit in order, then gives a done beat;
//   busy stays high until the done beat, so no new start is taken meanwhile
// reset: per-entry valid flops make every entry read empty; va base 0, 32 pages
// results are shown for one cycle on strobe; the receiver cannot stall
module page_table_with_swap_marks
    import ptsm_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int PAGE_SHIFT    = PAGE_SHIFT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // command side
    input  logic                 start,
    output logic                 busy,
    input  logic [OP_W-1:0]      op,
    input  logic [ADDR_W-1:0]    virt_addr,
    input  logic [ADDR_W-1:0]    operand_value,
    // result side
    output logic                 strobe,
    output logic [STAT_W-1:0]    status,
    output logic [CLASS_W-1:0]   entry_class,
    output logic [ADDR_W-1:0]    data,
    output logic                 last,
    // configuration
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data
);

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int VPN_W = ADDR_W - PAGE_SHIFT;
    localparam logic [ADDR_W-1:0]  PAGE_MASK = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [PAGES_W-1:0] ENTRIES_CAP = PAGES_W'(TABLE_ENTRIES);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]        va_base_reg;
    logic [PAGES_W-1:0]       pages_in_use_reg;
    logic [PAGES_W-1:0]       pos_reg, pos_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic                     vld_rd_reg;

    logic [OP_W-1:0]   op_reg;
    logic [ADDR_W-1:0] val_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              in_range_reg;

    logic               accept;
    logic [PAGES_W-1:0] limit;
    logic [ADDR_W-1:0]  page_diff;
    logic [VPN_W-1:0]   vpn;
    logic               in_range;
    logic [PAGES_W-1:0] pos_inc;
    logic               walk_end;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ADDR_W-1:0] ram_rdata;
    logic [ADDR_W-1:0] entry;
    logic [CLASS_W-1:0] cls;

    assign accept = start && !busy;

    // effective table limit
    assign limit = (pages_in_use_reg < ENTRIES_CAP) ? pages_in_use_reg : ENTRIES_CAP;

    // page index of the incoming address
    assign page_diff = (virt_addr & ~PAGE_MASK) - va_base_reg;
    assign vpn       = page_diff[ADDR_W-1:PAGE_SHIFT];
    assign in_range  = vpn < VPN_W'(limit);

    // clear walk position
    assign pos_inc  = pos_reg + PAGES_W'(1);
    assign walk_end = pos_inc >= limit;

    // entry as seen by the logic: not yet written reads as empty
    assign entry = vld_rd_reg ? ram_rdata : '0;

    always_comb
    begin
        if (entry == '0)
        begin
            cls = CLS_EMPTY;
        end
        else if (entry[0])
        begin
            cls = CLS_SWAPPED;
        end
        else
        begin
            cls = CLS_RESIDENT;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_base_reg      <= '0;
            pages_in_use_reg <= PAGES_W'(32);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_VA_BASE:      va_base_reg      <= cfg_data;
                CFG_PAGES_IN_USE: pages_in_use_reg <= cfg_data[PAGES_W-1:0];
                default:          va_base_reg      <= va_base_reg;
            endcase
        end
    end

    // command capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= op;
            val_reg      <= operand_value;
            idx_reg      <= vpn[IDX_W-1:0];
            in_range_reg <= in_range;
        end
    end

    // RAM read address
    always_comb
    begin
        case (state_reg)
            S_IDLE:  ram_raddr = (op == OP_CLEAR) ? '0 : vpn[IDX_W-1:0];
            S_WALK:  ram_raddr = pos_inc[IDX_W-1:0];
            default: ram_raddr = idx_reg;
        endcase
    end

    // RAM write: add and swap-out only, and only when the checks pass
    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = val_reg;
        if (state_reg == S_EXEC && in_range_reg)
        begin
            case (op_reg)
                OP_ADD:
                begin
                    ram_we = cls != CLS_RESIDENT;
                end
                OP_SWAP_OUT:
                begin
                    ram_we    = cls == CLS_RESIDENT;
                    ram_wdata = val_reg | ADDR_W'(1);
                end
                default:
                begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    ptsm_ram #(
        .WIDTH  (ADDR_W),
        .DEPTH  (TABLE_ENTRIES),
        .ADDR_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // valid bits: set on a write, dropped as the clear walk passes
    always_comb
    begin
        valid_next = valid_reg;
        if (ram_we)
        begin
            valid_next[idx_reg] = 1'b1;
        end
        if (state_reg == S_WALK)
        begin
            valid_next[pos_reg[IDX_W-1:0]] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            vld_rd_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            vld_rd_reg <= valid_reg[ram_raddr];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (op != OP_CLEAR)
                    begin
                        state_next = S_EXEC;
                    end
                    else if (limit == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            S_WALK:
            begin
                if (walk_end)
                begin
                    pos_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // result beat
    always_comb
    begin
        busy        = state_reg != S_IDLE;
        strobe      = 1'b0;
        status      = ST_OK;
        entry_class = CLS_EMPTY;
        data        = '0;
        last        = 1'b0;
        case (state_reg)
            S_EXEC:
            begin
                strobe = 1'b1;
                last   = 1'b1;
                if (op_reg > OP_CLEAR)
                begin
                    status = ST_BAD_STATE;
                end
                else if (!in_range_reg)
                begin
                    status = ST_OUTSIDE;
                end
                else
                begin
                    entry_class = cls;
                    case (op_reg)
                        OP_LOOKUP:
                        begin
                            data = entry & ~ADDR_W'(1);
                        end
                        OP_ADD:
                        begin
                            if (cls == CLS_RESIDENT)
                            begin
                                status = ST_BAD_STATE;
                            end
                            else
                            begin
                                data = val_reg;
                            end
                        end
                        OP_SWAP_OUT:
                        begin
                            if (cls != CLS_RESIDENT)
                            begin
                                status = ST_BAD_STATE;
                            end
                            else
                            begin
                                data = entry;
                            end
                        end
                        default:
                        begin
                            if (cls != CLS_SWAPPED)
                            begin
                                status = ST_BAD_STATE;
                            end
                            else
                            begin
                                data = entry & ~ADDR_W'(1);
                            end
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                strobe = cls != CLS_EMPTY;
                data   = entry & ~ADDR_W'(1);
                if (cls == CLS_SWAPPED)
                begin
                    entry_class = CLS_FREE_SWAP;
                end
                else
                begin
                    entry_class = CLS_FREE_PAGE;
                end
            end
            S_DONE:
            begin
                strobe = 1'b1;
                last   = 1'b1;
            end
            default:
            begin
                strobe = 1'b0;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a final beat always returns the block to idle
    assert property (@(posedge clk) disable iff (!rst_n) (strobe && last) |=> !busy)
        else $error("block still busy after final beat");

    // no result beat while idle
    assert property (@(posedge clk) disable iff (!rst_n) strobe |-> busy)
        else $error("result beat while idle");

    // the walk position is parked at zero whenever no clear is running
    assert property (@(posedge clk) disable iff (!rst_n) (state_reg != S_WALK) |-> (pos_reg == '0))
        else $error("clear position not parked");

    // the table is written only for an in-range entry
    assert property (@(posedge clk) disable iff (!rst_n) ram_we |-> (in_range_reg && busy))
        else $error("table write outside range");
`endif

endmodule
